// ----- hdl/slm_pkg.sv -----
// ----------------------------------------------------------------------------
// slm_pkg - shared types and constants for the sorted list merge block
// Field widths, item codes and controller state encoding.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int DATA_W        = 32;
  localparam int LIST_DEPTH_DEF = 32;
  localparam int CAP_W         = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  // input item kind (s_tuser)
  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_MERGE  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // result item kind (m_tuser)
  typedef enum logic [1:0] {
    STAT_ELEM  = 2'd0,
    STAT_CAP   = 2'd1,
    STAT_DROP  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  // register indexes
  localparam logic [0:0] REG_OUT_CAPACITY = 1'b0;

endpackage

// ----- hdl/slm_ram.sv -----
// ----------------------------------------------------------------------------
// slm_ram - generic single-port-write, single-port-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/slm_cfg.sv -----
// ----------------------------------------------------------------------------
// slm_cfg - APB register file
// Holds out_capacity; write on the access phase, read returns the value.
// ----------------------------------------------------------------------------
module slm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slm_pkg::PADDR_W-1:0]         paddr,
  input  logic [slm_pkg::PDATA_W-1:0]         pwdata,
  output logic [slm_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  output logic [slm_pkg::CAP_W-1:0]           out_capacity
);
  import slm_pkg::*;

  logic reg_hit;

  // word index is paddr[2]; byte lanes ignored
  assign reg_hit = (paddr[PADDR_W-1 -: 1] == REG_OUT_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      out_capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(out_capacity) : '0;

endmodule

// ----- hdl/sorted_list_merge.sv -----
// ----------------------------------------------------------------------------
// sorted_list_merge - two-way merge of two ascending signed lists
// Loads lists A and B into RAM, then streams their stable merge.
// ----------------------------------------------------------------------------
// Each list lives in its own RAM of LIST_DEPTH 32-bit words with registered
// read. Load items (tuser 0 = A, 1 = B) produce no result unless the list
// is full, in which case one drop status item comes out. A merge item
// (tuser 2) checks countA + countB against out_capacity: too long gives one
// capacity status item, two empty lists give one empty status item,
// otherwise the merged elements come out one per cycle while the output is
// not stalled, A winning ties, tlast on the final one. Input is held off
// (s_tready low) while a merge streams. The rate is set by the single read
// port of each RAM, which is kept pointed at the current head of each list
// so the next compare always has both heads in the cycle after a pick. Both
// lists are empty after every merge item. tuser 3 is accepted and ignored.
// The RAMs have no reset: entries beyond a list's count are never looked at.
// ----------------------------------------------------------------------------
module sorted_list_merge #(
  parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slm_pkg::PADDR_W-1:0]    paddr,
  input  logic [slm_pkg::PDATA_W-1:0]    pwdata,
  output logic [slm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [slm_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value
  input  logic [1:0]                     s_tuser,   // [1:0] mode
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [slm_pkg::DATA_W-1:0]     m_tdata,   // [31:0] out_value
  output logic [1:0]                     m_tuser,   // [1:0] status
  output logic                           m_tlast
);
  import slm_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = ((SW > CAP_W) ? SW : CAP_W) + 1;   // compare width

  state_t state, state_next;

  logic [CAP_W-1:0]  out_capacity;
  logic [CW-1:0]     count_a, count_a_next, count_b, count_b_next;
  logic [CW-1:0]     ia, ia_next, jb, jb_next;  // read heads
  logic [SW-1:0]     total;
  logic              full_a, full_b;
  logic              out_free, in_acc;
  mode_t             mode;

  logic              we_a, we_b;
  logic [DATA_W-1:0] rd_a, rd_b;

  // output register load
  logic              out_load;
  logic [DATA_W-1:0] out_data;
  status_t           out_stat;
  logic              out_last;

  // merge pick
  logic              a_ok, b_ok, take_a;

  slm_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .out_capacity (out_capacity)
  );

  // read address follows the next head so rdata is always mem[head]
  slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[AW-1:0]),
    .wdata (s_tdata),
    .raddr (ia_next[AW-1:0]),
    .rdata (rd_a)
  );

  slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[AW-1:0]),
    .wdata (s_tdata),
    .raddr (jb_next[AW-1:0]),
    .rdata (rd_b)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;
  assign mode     = mode_t'(s_tuser);
  assign full_a   = (count_a == CW'(LIST_DEPTH));
  assign full_b   = (count_b == CW'(LIST_DEPTH));
  assign total    = SW'(count_a) + SW'(count_b);

  assign we_a = in_acc && (mode == MODE_LOAD_A) && !full_a;
  assign we_b = in_acc && (mode == MODE_LOAD_B) && !full_b;

  // A wins ties (stable)
  assign a_ok   = (ia < count_a);
  assign b_ok   = (jb < count_b);
  assign take_a = a_ok && (!b_ok || ($signed(rd_a) <= $signed(rd_b)));

  always_comb begin
    state_next   = state;
    count_a_next = count_a;
    count_b_next = count_b;
    ia_next      = ia;
    jb_next      = jb;
    out_load     = 1'b0;
    out_data     = '0;
    out_stat     = STAT_ELEM;
    out_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode)
            MODE_LOAD_A: begin
              if (full_a) begin
                out_load = 1'b1;
                out_stat = STAT_DROP;
              end else begin
                count_a_next = count_a + CW'(1);
              end
            end
            MODE_LOAD_B: begin
              if (full_b) begin
                out_load = 1'b1;
                out_stat = STAT_DROP;
              end else begin
                count_b_next = count_b + CW'(1);
              end
            end
            MODE_MERGE: begin
              if (XW'(total) > XW'(out_capacity)) begin
                out_load     = 1'b1;
                out_stat     = STAT_CAP;
                count_a_next = '0;
                count_b_next = '0;
              end else if (total == '0) begin
                out_load = 1'b1;
                out_stat = STAT_EMPTY;
              end else begin
                state_next = ST_MERGE;
              end
            end
            default: ;  // ignored kind
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_stat = STAT_ELEM;
          out_data = take_a ? rd_a : rd_b;
          if (take_a) begin
            ia_next = ia + CW'(1);
          end else begin
            jb_next = jb + CW'(1);
          end
          out_last = (ia_next == count_a) && (jb_next == count_b);
          if (out_last) begin
            state_next   = ST_IDLE;
            count_a_next = '0;
            count_b_next = '0;
            ia_next      = '0;
            jb_next      = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_a <= '0;
      count_b <= '0;
      ia      <= '0;
      jb      <= '0;
    end else begin
      state   <= state_next;
      count_a <= count_a_next;
      count_b <= count_b_next;
      ia      <= ia_next;
      jb      <= jb_next;
    end
  end

  // output register: decouples the result side from the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_data;
      m_tuser <= out_stat;
      m_tlast <= out_last;
    end
  end

  // heads never run past their list
  a_heads_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (ia <= count_a && jb <= count_b))
    else $error("merge head beyond list count");

  // a merge in flight always has something left to emit
  a_merge_not_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (a_ok || b_ok))
    else $error("merge state with both lists drained");

  // input only taken while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input ready outside idle");

  // finishing the last element returns to idle with empty lists
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE && out_load && out_last) |=>
      (state == ST_IDLE && count_a == '0 && count_b == '0))
    else $error("lists not cleared after merge");

endmodule
